@@ rtl/core/src16_pkg.sv @@
// Shared types, opcodes and helpers of the 16-bit core.
`timescale 1ns / 1ps
`default_nettype none
package src16_pkg;

	localparam int unsigned AddrW  = 16;
	localparam int unsigned DataW  = 16;
	localparam int unsigned NumGpr = 8;

	localparam logic [15:0] PC_RESET   = 16'h8200;
	localparam logic [15:0] OS_BASE    = 16'h8000;
	localparam logic [15:0] OS_DATA    = 16'hA000;
	localparam logic [15:0] USR_DATA   = 16'h4000;
	localparam logic [15:0] USR_CODE_D = 16'h2000;

	// Opcodes, bits 15:12
	localparam logic [3:0] OPC_BR    = 4'd0;
	localparam logic [3:0] OPC_ARITH = 4'd1;
	localparam logic [3:0] OPC_CMP   = 4'd2;
	localparam logic [3:0] OPC_JSR   = 4'd4;
	localparam logic [3:0] OPC_LOGIC = 4'd5;
	localparam logic [3:0] OPC_LDR   = 4'd6;
	localparam logic [3:0] OPC_STR   = 4'd7;
	localparam logic [3:0] OPC_RTI   = 4'd8;
	localparam logic [3:0] OPC_CONST = 4'd9;
	localparam logic [3:0] OPC_SHIFT = 4'd10;
	localparam logic [3:0] OPC_JMP   = 4'd12;
	localparam logic [3:0] OPC_HICON = 4'd13;
	localparam logic [3:0] OPC_TRAP  = 4'd15;

	// Status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_USR_FETCH = 3'd1;
	localparam logic [2:0] ST_DATA_EXE  = 3'd2;
	localparam logic [2:0] ST_CODE_ACC  = 3'd3;
	localparam logic [2:0] ST_OS_ACC    = 3'd4;
	localparam logic [2:0] ST_BAD_OPC   = 3'd5;

	// Flag codes
	localparam logic [2:0] NZP_P = 3'd1;
	localparam logic [2:0] NZP_Z = 3'd2;
	localparam logic [2:0] NZP_N = 3'd4;

	typedef enum logic [2:0] {
		S_IDLE, S_FETCH, S_RDA, S_RDB, S_EXEC, S_MEMW, S_WB
	} seq_state_t;

	typedef enum logic [3:0] {
		ALU_ADD, ALU_SUB, ALU_MUL, ALU_AND, ALU_OR, ALU_XOR, ALU_NOT,
		ALU_SLL, ALU_SRA, ALU_SRL, ALU_DIV, ALU_MOD, ALU_CMPS, ALU_CMPU, ALU_PASS
	} alu_op_t;

	typedef struct packed {
		alu_op_t op;
		logic    start;
	} alu_ctl_t;

	function automatic logic [2:0] nzp_of(input logic [15:0] v);
		logic [2:0] r;
		if (v == 16'd0)
			r = NZP_Z;
		else if (v[15])
			r = NZP_N;
		else
			r = NZP_P;
		return r;
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/src16_mem.sv @@
// Main memory with a clearing sweep after reset.
`timescale 1ns / 1ps
`default_nettype none
module src16_mem (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        we,
	input  wire logic [15:0] waddr,
	input  wire logic [15:0] wdata,
	input  wire logic        re,
	input  wire logic [15:0] raddr,
	output logic      [15:0] rdata,
	output logic             clr_busy
);
	logic [15:0] mem [0:65535];
	logic [16:0] clr_cnt_q;

	assign clr_busy = ~clr_cnt_q[16];

	// Advance the clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_cnt_q <= 17'd0;
		else if (clr_busy)
			clr_cnt_q <= clr_cnt_q + 17'd1;
	end

	// Write one word, zero during the sweep
	always_ff @(posedge clk) begin
		if (clr_busy)
			mem[clr_cnt_q[15:0]] <= 16'd0;
		else if (we)
			mem[waddr] <= wdata;
	end

	// Registered read
	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ rtl/core/src16_alu.sv @@
// Shared arithmetic unit with an iterative divider.
`timescale 1ns / 1ps
`default_nettype none
module src16_alu (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire src16_pkg::alu_ctl_t  ctl,
	input  wire logic [15:0]          a,
	input  wire logic [15:0]          b,
	output logic      [15:0]          res,
	output logic      [2:0]           flags,
	output logic                      done
);
	logic [15:0] rem_q, quo_q;
	logic [4:0]  cnt_q;
	logic        busy_q, fin_q;
	logic [16:0] r17, diff;
	logic        is_div;
	logic [31:0] prod;

	assign is_div = (ctl.op == src16_pkg::ALU_DIV) || (ctl.op == src16_pkg::ALU_MOD);
	assign r17    = {rem_q, quo_q[15]};
	assign diff   = r17 - {1'b0, b};
	assign prod   = a * b;

	// Restoring divide, one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			cnt_q  <= 5'd0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			fin_q  <= 1'b0;
			cnt_q  <= 5'd16;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) begin
				busy_q <= 1'b0;
				fin_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= 16'd0;
			quo_q <= a;
		end else if (busy_q) begin
			rem_q <= diff[16] ? r17[15:0] : diff[15:0];
			quo_q <= {quo_q[14:0], ~diff[16]};
		end
	end

	assign done = !is_div || (b == 16'd0) || (fin_q && !ctl.start);

	// Select the operation
	always_comb begin
		res   = 16'd0;
		flags = src16_pkg::NZP_Z;
		case (ctl.op)
			src16_pkg::ALU_ADD:  res = a + b;
			src16_pkg::ALU_SUB:  res = a - b;
			src16_pkg::ALU_MUL:  res = prod[15:0];
			src16_pkg::ALU_AND:  res = a & b;
			src16_pkg::ALU_OR:   res = a | b;
			src16_pkg::ALU_XOR:  res = a ^ b;
			src16_pkg::ALU_NOT:  res = ~a;
			src16_pkg::ALU_SLL:  res = a << b[3:0];
			src16_pkg::ALU_SRA:  res = 16'($signed(a) >>> b[3:0]);
			src16_pkg::ALU_SRL:  res = a >> b[3:0];
			src16_pkg::ALU_DIV:  res = (b == 16'd0) ? 16'd0 : quo_q;
			src16_pkg::ALU_MOD:  res = (b == 16'd0) ? 16'd0 : rem_q;
			src16_pkg::ALU_CMPS: begin
				if ($signed(a) > $signed(b))
					flags = src16_pkg::NZP_P;
				else if (a == b)
					flags = src16_pkg::NZP_Z;
				else
					flags = src16_pkg::NZP_N;
			end
			src16_pkg::ALU_CMPU: begin
				if (a > b)
					flags = src16_pkg::NZP_P;
				else if (a == b)
					flags = src16_pkg::NZP_Z;
				else
					flags = src16_pkg::NZP_N;
			end
			default: res = b;
		endcase
	end
endmodule
`default_nettype wire

@@ rtl/core/sixteen_bit_risc_core_step.sv @@
// Top level: sequencer, register file and trace output of the 16-bit core.
//
// Channel | Direction | Handshake           | Payload
// input   | in        | in_valid / in_ready | op, load_addr, load_data
// output  | out       | out_valid/out_ready | pc_before .. status (11 fields)
//
// A load item is written to memory when taken. Sharing the single memory port, a step
// item runs through fetch, operand reads, execute (waiting for the bit-serial divider
// on DIV or MOD with a nonzero divisor), a memory read for a permitted LDR and
// write-back; a fetch fault skips to write-back. After reset the memory is swept
// to zero, taking no item. A step finishes only when the output register is free.
`timescale 1ns / 1ps
`default_nettype none
module sixteen_bit_risc_core_step (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        op,
	input  wire logic [15:0] load_addr,
	input  wire logic [15:0] load_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [15:0] pc_before,
	output logic      [15:0] insn_word,
	output logic             reg_we,
	output logic      [2:0]  reg_index,
	output logic      [15:0] reg_value,
	output logic             nzp_we,
	output logic      [2:0]  nzp_value,
	output logic             data_we,
	output logic      [15:0] mem_addr,
	output logic      [15:0] mem_value,
	output logic      [2:0]  status
);
	src16_pkg::seq_state_t state_q, state_d;

	logic [15:0] pc_q, w_q, a_q, b_q, res_q, next_q, maddr_q, mval_q;
	logic        priv_q, we_q, fwe_q, dwe_q, exec_first_q;
	logic [2:0]  flags_q, fl_q, widx_q, status_q;
	logic [15:0] gpr_q [src16_pkg::NumGpr];

	logic [3:0]  opc;
	logic [2:0]  rd, rs, rt, a_idx, b_idx;
	logic [15:0] sx5, sx6, sx7, sx9, sx11, pc_inc;
	logic        in_acc, commit, fetch_fault;
	logic [2:0]  fetch_status;

	logic        mem_we, mem_re, clr_busy;
	logic [15:0] mem_waddr, mem_wdata, mem_raddr, mem_rdata;

	src16_pkg::alu_ctl_t alu_ctl;
	logic [15:0] alu_b, alu_res;
	logic [2:0]  alu_flags;
	logic        alu_done;

	// Field decode
	assign opc    = w_q[15:12];
	assign rd     = w_q[11:9];
	assign rs     = w_q[8:6];
	assign rt     = w_q[2:0];
	assign sx5    = {{11{w_q[4]}}, w_q[4:0]};
	assign sx6    = {{10{w_q[5]}}, w_q[5:0]};
	assign sx7    = {{9{w_q[6]}}, w_q[6:0]};
	assign sx9    = {{7{w_q[8]}}, w_q[8:0]};
	assign sx11   = {{5{w_q[10]}}, w_q[10:0]};
	assign pc_inc = pc_q + 16'd1;

	assign a_idx = (opc == src16_pkg::OPC_CMP || opc == src16_pkg::OPC_HICON) ? rd :
	               (opc == src16_pkg::OPC_RTI) ? 3'd7 : rs;
	assign b_idx = (opc == src16_pkg::OPC_STR) ? rd : rt;

	assign in_ready = (state_q == src16_pkg::S_IDLE) && !clr_busy;
	assign in_acc   = in_valid && in_ready;
	assign commit   = (state_q == src16_pkg::S_WB) && (!out_valid || out_ready);

	// Fetch checks against the memory map
	always_comb begin
		fetch_status = src16_pkg::ST_OK;
		if (pc_q >= src16_pkg::OS_BASE && !priv_q)
			fetch_status = src16_pkg::ST_USR_FETCH;
		else if ((pc_q >= src16_pkg::USR_DATA && pc_q < src16_pkg::OS_BASE) ||
		         pc_q >= src16_pkg::OS_DATA)
			fetch_status = src16_pkg::ST_DATA_EXE;
	end
	assign fetch_fault = (fetch_status != src16_pkg::ST_OK);

	// Pick the shared unit's operation
	always_comb begin
		alu_ctl.op = src16_pkg::ALU_PASS;
		alu_b      = b_q;
		case (opc)
			src16_pkg::OPC_ARITH: begin
				if (w_q[5]) begin
					alu_ctl.op = src16_pkg::ALU_ADD;
					alu_b      = sx5;
				end else begin
					case (w_q[4:3])
						2'd0:    alu_ctl.op = src16_pkg::ALU_ADD;
						2'd1:    alu_ctl.op = src16_pkg::ALU_MUL;
						2'd2:    alu_ctl.op = src16_pkg::ALU_SUB;
						default: alu_ctl.op = src16_pkg::ALU_DIV;
					endcase
				end
			end
			src16_pkg::OPC_CMP: begin
				case (w_q[8:7])
					2'd0: alu_ctl.op = src16_pkg::ALU_CMPS;
					2'd1: alu_ctl.op = src16_pkg::ALU_CMPU;
					2'd2: begin
						alu_ctl.op = src16_pkg::ALU_CMPS;
						alu_b      = sx7;
					end
					default: begin
						alu_ctl.op = src16_pkg::ALU_CMPU;
						alu_b      = {9'd0, w_q[6:0]};
					end
				endcase
			end
			src16_pkg::OPC_LOGIC: begin
				if (w_q[5]) begin
					alu_ctl.op = src16_pkg::ALU_AND;
					alu_b      = sx5;
				end else begin
					case (w_q[4:3])
						2'd0:    alu_ctl.op = src16_pkg::ALU_AND;
						2'd1:    alu_ctl.op = src16_pkg::ALU_NOT;
						2'd2:    alu_ctl.op = src16_pkg::ALU_OR;
						default: alu_ctl.op = src16_pkg::ALU_XOR;
					endcase
				end
			end
			src16_pkg::OPC_LDR, src16_pkg::OPC_STR: begin
				alu_ctl.op = src16_pkg::ALU_ADD;
				alu_b      = sx6;
			end
			src16_pkg::OPC_SHIFT: begin
				alu_b = {12'd0, w_q[3:0]};
				case (w_q[5:4])
					2'd0: alu_ctl.op = src16_pkg::ALU_SLL;
					2'd1: alu_ctl.op = src16_pkg::ALU_SRA;
					2'd2: alu_ctl.op = src16_pkg::ALU_SRL;
					default: begin
						alu_ctl.op = src16_pkg::ALU_MOD;
						alu_b      = b_q;
					end
				endcase
			end
			default: alu_ctl.op = src16_pkg::ALU_PASS;
		endcase
		alu_ctl.start = (state_q == src16_pkg::S_EXEC) && exec_first_q &&
		                (alu_ctl.op == src16_pkg::ALU_DIV || alu_ctl.op == src16_pkg::ALU_MOD);
	end

	src16_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (alu_ctl),
		.a      (a_q),
		.b      (alu_b),
		.res    (alu_res),
		.flags  (alu_flags),
		.done   (alu_done)
	);

	// Memory port use: loads and fetches in idle, data access in execute
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = load_addr;
		mem_wdata = load_data;
		mem_re    = 1'b0;
		mem_raddr = pc_q;
		if (state_q == src16_pkg::S_IDLE) begin
			mem_we = in_acc && !op;
			mem_re = in_acc && op;
		end else if (state_q == src16_pkg::S_EXEC && alu_done &&
		             (opc == src16_pkg::OPC_LDR || opc == src16_pkg::OPC_STR)) begin
			mem_waddr = alu_res;
			mem_wdata = b_q;
			mem_raddr = alu_res;
			if (!(alu_res < src16_pkg::USR_CODE_D ||
			      (alu_res >= src16_pkg::OS_BASE && alu_res < src16_pkg::OS_DATA)) &&
			    !(alu_res >= src16_pkg::OS_DATA && !priv_q)) begin
				mem_we = (opc == src16_pkg::OPC_STR);
				mem_re = (opc == src16_pkg::OPC_LDR);
			end
		end
	end

	src16_mem u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.we       (mem_we),
		.waddr    (mem_waddr),
		.wdata    (mem_wdata),
		.re       (mem_re),
		.raddr    (mem_raddr),
		.rdata    (mem_rdata),
		.clr_busy (clr_busy)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= src16_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			src16_pkg::S_IDLE:  if (in_acc && op) state_d = src16_pkg::S_FETCH;
			src16_pkg::S_FETCH: state_d = src16_pkg::S_RDA;
			src16_pkg::S_RDA:   state_d = fetch_fault ? src16_pkg::S_WB : src16_pkg::S_RDB;
			src16_pkg::S_RDB:   state_d = src16_pkg::S_EXEC;
			src16_pkg::S_EXEC:  if (alu_done) state_d = mem_re ? src16_pkg::S_MEMW : src16_pkg::S_WB;
			src16_pkg::S_MEMW:  state_d = src16_pkg::S_WB;
			src16_pkg::S_WB:    if (commit) state_d = src16_pkg::S_IDLE;
			default:            state_d = src16_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			exec_first_q <= 1'b0;
		else
			exec_first_q <= (state_q == src16_pkg::S_RDB);
	end

	// Capture instruction, operands and pending results
	always_ff @(posedge clk) begin
		unique case (state_q)
			src16_pkg::S_FETCH: w_q <= mem_rdata;
			src16_pkg::S_RDA: begin
				a_q      <= gpr_q[a_idx];
				status_q <= fetch_status;
				we_q     <= 1'b0;
				fwe_q    <= 1'b0;
				dwe_q    <= 1'b0;
				widx_q   <= 3'd0;
				res_q    <= 16'd0;
				fl_q     <= 3'd0;
				maddr_q  <= 16'd0;
				mval_q   <= 16'd0;
				next_q   <= pc_q;
			end
			src16_pkg::S_RDB: b_q <= gpr_q[b_idx];
			src16_pkg::S_EXEC: if (alu_done) begin
				next_q <= pc_inc;
				case (opc)
					src16_pkg::OPC_BR:
						if ((w_q[11:9] & flags_q) != 3'd0)
							next_q <= pc_inc + sx9;
					src16_pkg::OPC_ARITH, src16_pkg::OPC_LOGIC, src16_pkg::OPC_SHIFT: begin
						we_q <= 1'b1; widx_q <= rd; res_q <= alu_res;
						fwe_q <= 1'b1; fl_q <= src16_pkg::nzp_of(alu_res);
					end
					src16_pkg::OPC_CMP: begin
						fwe_q <= 1'b1; fl_q <= alu_flags;
					end
					src16_pkg::OPC_JSR: begin
						next_q <= w_q[11] ? {pc_q[15], w_q[10:0], 4'd0} : a_q;
						we_q <= 1'b1; widx_q <= 3'd7; res_q <= pc_inc;
						fwe_q <= 1'b1; fl_q <= src16_pkg::nzp_of(pc_inc);
					end
					src16_pkg::OPC_LDR, src16_pkg::OPC_STR: begin
						if (alu_res < src16_pkg::USR_CODE_D ||
						    (alu_res >= src16_pkg::OS_BASE && alu_res < src16_pkg::OS_DATA))
							status_q <= src16_pkg::ST_CODE_ACC;
						else if (alu_res >= src16_pkg::OS_DATA && !priv_q)
							status_q <= src16_pkg::ST_OS_ACC;
						else begin
							maddr_q <= alu_res;
							if (opc == src16_pkg::OPC_STR) begin
								dwe_q  <= 1'b1;
								mval_q <= b_q;
							end
						end
					end
					src16_pkg::OPC_RTI: next_q <= a_q;
					src16_pkg::OPC_CONST: begin
						we_q <= 1'b1; widx_q <= rd; res_q <= sx9;
						fwe_q <= 1'b1; fl_q <= src16_pkg::nzp_of(sx9);
					end
					src16_pkg::OPC_JMP: next_q <= w_q[11] ? pc_inc + sx11 : a_q;
					src16_pkg::OPC_HICON: begin
						we_q <= 1'b1; widx_q <= rd; res_q <= {w_q[7:0], a_q[7:0]};
						fwe_q <= 1'b1; fl_q <= src16_pkg::nzp_of({w_q[7:0], a_q[7:0]});
					end
					src16_pkg::OPC_TRAP: begin
						next_q <= {8'h80, w_q[7:0]};
						we_q <= 1'b1; widx_q <= 3'd7; res_q <= pc_inc;
						fwe_q <= 1'b1; fl_q <= src16_pkg::nzp_of(pc_inc);
					end
					default: begin
						status_q <= src16_pkg::ST_BAD_OPC;
						next_q   <= pc_q;
					end
				endcase
			end
			src16_pkg::S_MEMW: begin
				we_q <= 1'b1; widx_q <= rd; res_q <= mem_rdata;
				fwe_q <= 1'b1; fl_q <= src16_pkg::nzp_of(mem_rdata);
				mval_q <= mem_rdata;
			end
			default: ;
		endcase
	end

	// Commit architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= src16_pkg::PC_RESET;
			priv_q  <= 1'b1;
			flags_q <= src16_pkg::NZP_Z;
			for (int i = 0; i < src16_pkg::NumGpr; i++)
				gpr_q[i] <= 16'd0;
		end else if (commit) begin
			pc_q <= next_q;
			if (we_q)
				gpr_q[widx_q] <= res_q;
			if (fwe_q)
				flags_q <= fl_q;
			if (status_q == src16_pkg::ST_OK) begin
				if (opc == src16_pkg::OPC_RTI)
					priv_q <= 1'b0;
				else if (opc == src16_pkg::OPC_TRAP)
					priv_q <= 1'b1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (commit)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			pc_before <= pc_q;
			insn_word <= w_q;
			reg_we    <= we_q;
			reg_index <= widx_q;
			reg_value <= res_q;
			nzp_we    <= fwe_q;
			nzp_value <= fl_q;
			data_we   <= dwe_q;
			mem_addr  <= maddr_q;
			mem_value <= mval_q;
			status    <= status_q;
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/src16_checker.sv @@
// Port-level checks of the 16-bit core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module src16_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        op,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        reg_we,
	input wire logic [2:0]  reg_index,
	input wire logic [15:0] reg_value,
	input wire logic        nzp_we,
	input wire logic        data_we,
	input wire logic [15:0] mem_addr,
	input wire logic [2:0]  status
);
	// Hold a result until it is taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before it was taken");

	// A step item keeps the block busy for the next cycle
	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && op |=> !in_ready)
		else $error("item taken while a step is running");

	// Faults write nothing
	a_fault_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != src16_pkg::ST_OK |->
			!reg_we && !nzp_we && !data_we && mem_addr == 16'd0)
		else $error("faulting item changed state");

	// No register write means zero index and value
	a_no_wr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !reg_we |-> reg_index == 3'd0 && reg_value == 16'd0)
		else $error("register fields set without a write");
endmodule

bind sixteen_bit_risc_core_step src16_checker u_src16_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.op        (op),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.reg_we    (reg_we),
	.reg_index (reg_index),
	.reg_value (reg_value),
	.nzp_we    (nzp_we),
	.data_we   (data_we),
	.mem_addr  (mem_addr),
	.status    (status)
);
`default_nettype wire
